// ----- rtl/core/slpc_pkg.sv -----
// Shared types and constants for the status LED pattern controller.
// No dependencies; every other file of the block depends on this package.
package slpc_pkg;

    localparam int LEVEL_W    = 10;
    localparam int TIME_W     = 12;
    localparam int AGE_W      = 8;
    localparam int CMD_W      = 3;
    localparam int MODE_W     = 3;
    localparam int PCODE_W    = 32;
    localparam int BITPOS_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OFF        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONNECTING = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONNECTED  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACTIVITY   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PANIC      = 3'd5;

    // Mode codes as seen on the result channel
    localparam logic [MODE_W-1:0] MODE_CODE_OFF      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_BREATH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_ON       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_ACTIVITY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CODE_PANIC    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MS     = 3'd5;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] RST_BRIGHT_LEVEL = 10'd32;
    localparam logic [TIME_W-1:0]  RST_FRAME_MS     = 12'd50;
    localparam logic [AGE_W-1:0]   RST_HOLD_MS      = 8'd100;
    localparam logic [TIME_W-1:0]  RST_SHORT_MS     = 12'd250;
    localparam logic [TIME_W-1:0]  RST_LONG_MS      = 12'd500;
    localparam logic [TIME_W-1:0]  RST_PAUSE_MS     = 12'd3000;

    localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

    typedef enum logic [4:0] {
        MODE_OFF      = 5'b00001,
        MODE_BREATH   = 5'b00010,
        MODE_ON       = 5'b00100,
        MODE_ACTIVITY = 5'b01000,
        MODE_PANIC    = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [LEVEL_W-1:0] bright_level;
        logic [TIME_W-1:0]  frame_ms;
        logic [AGE_W-1:0]   activity_hold_ms;
        logic [TIME_W-1:0]  short_ms;
        logic [TIME_W-1:0]  long_ms;
        logic [TIME_W-1:0]  pause_ms;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm_duty;
        logic [MODE_W-1:0]  mode;
    } t_result;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_OFF:      c = MODE_CODE_OFF;
            MODE_BREATH:   c = MODE_CODE_BREATH;
            MODE_ON:       c = MODE_CODE_ON;
            MODE_ACTIVITY: c = MODE_CODE_ACTIVITY;
            MODE_PANIC:    c = MODE_CODE_PANIC;
            default:       c = MODE_CODE_OFF;
        endcase
        return c;
    endfunction

    // Mode requested by a request command; tick and unused codes map to off
    // but are never used as requests.
    function automatic t_mode cmd_to_mode(input logic [CMD_W-1:0] cmd);
        t_mode m;
        unique case (cmd)
            CMD_OFF:        m = MODE_OFF;
            CMD_CONNECTING: m = MODE_BREATH;
            CMD_CONNECTED:  m = MODE_ON;
            CMD_ACTIVITY:   m = MODE_ACTIVITY;
            CMD_PANIC:      m = MODE_PANIC;
            default:        m = MODE_OFF;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/slpc_cmd_if.sv -----
// Command channel: valid/ready handshake carrying cmd and panic_code.
// Depends on slpc_pkg for field widths.
interface slpc_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [slpc_pkg::CMD_W-1:0]   cmd;
    logic [slpc_pkg::PCODE_W-1:0] panic_code;

    modport source (output valid, output cmd, output panic_code, input ready);
    modport sink   (input valid, input cmd, input panic_code, output ready);
endinterface

// ----- rtl/core/slpc_led_if.sv -----
// Result channel: valid/ready handshake carrying pwm_duty and mode.
// Depends on slpc_pkg for field widths.
interface slpc_led_if;
    logic                         valid;
    logic                         ready;
    logic [slpc_pkg::LEVEL_W-1:0] pwm_duty;
    logic [slpc_pkg::MODE_W-1:0]  mode;

    modport source (output valid, output pwm_duty, output mode, input ready);
    modport sink   (input valid, input pwm_duty, input mode, output ready);
endinterface

// ----- rtl/core/status_led_pattern_controller.sv -----
// Status LED pattern controller: ms ticks and mode requests in, PWM level out.
// Results are registered in the output buffer (skid register while stalled).
// Throughput: one transaction per cycle while the skid register is empty; set
// by the next-state logic of the mode engine and a two-entry output buffer.
// Reset: synchronous, active low; all state and configuration take their
// reset values directly, no clearing pass; the buffer's data is not reset.
module status_led_pattern_controller #(
    parameter int BREATH_STEPS = 20,
    parameter int CODE_BITS    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    slpc_cmd_if.sink                        i_cmd,
    slpc_led_if.source                      o_led
);
    import slpc_pkg::*;

    t_cfg    cfg;
    t_result eng_result;
    t_result out_data;
    logic    in_ready;
    logic    in_fire;

    assign i_cmd.ready = in_ready;
    assign in_fire     = i_cmd.valid && in_ready;

    slpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    slpc_engine #(
        .BREATH_STEPS (BREATH_STEPS),
        .CODE_BITS    (CODE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_cmd        (i_cmd.cmd),
        .i_panic_code (i_cmd.panic_code),
        .i_cfg        (cfg),
        .o_result     (eng_result)
    );

    slpc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_fire),
        .i_data  (eng_result),
        .o_ready (in_ready),
        .o_valid (o_led.valid),
        .o_data  (out_data),
        .i_ready (o_led.ready)
    );

    assign o_led.pwm_duty = out_data.pwm_duty;
    assign o_led.mode     = out_data.mode;

endmodule

// ----- rtl/core/slpc_cfg.sv -----
// Configuration register file of the status LED pattern controller.
// Depends on slpc_pkg for t_cfg, register indexes and reset values.
module slpc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output slpc_pkg::t_cfg                  o_cfg
);
    import slpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BRIGHT_LEVEL: n_cfg.bright_level     = i_cfg_data[LEVEL_W-1:0];
                CFG_FRAME_MS:     n_cfg.frame_ms         = i_cfg_data[TIME_W-1:0];
                CFG_HOLD_MS:      n_cfg.activity_hold_ms = i_cfg_data[AGE_W-1:0];
                CFG_SHORT_MS:     n_cfg.short_ms         = i_cfg_data[TIME_W-1:0];
                CFG_LONG_MS:      n_cfg.long_ms          = i_cfg_data[TIME_W-1:0];
                CFG_PAUSE_MS:     n_cfg.pause_ms         = i_cfg_data[TIME_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bright_level     <= RST_BRIGHT_LEVEL;
            r_cfg.frame_ms         <= RST_FRAME_MS;
            r_cfg.activity_hold_ms <= RST_HOLD_MS;
            r_cfg.short_ms         <= RST_SHORT_MS;
            r_cfg.long_ms          <= RST_LONG_MS;
            r_cfg.pause_ms         <= RST_PAUSE_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/slpc_engine.sv -----
// Mode engine: pattern state registers and the combinational next-state logic.
// Depends on slpc_pkg for modes, commands, t_cfg and t_result.
module slpc_engine #(
    parameter int BREATH_STEPS = 20,
    parameter int CODE_BITS    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [slpc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [slpc_pkg::PCODE_W-1:0] i_panic_code,
    input  slpc_pkg::t_cfg               i_cfg,
    output slpc_pkg::t_result            o_result
);
    import slpc_pkg::*;

    localparam int SW = $clog2(BREATH_STEPS);
    localparam logic [SW:0] NSTEPS    = (SW+1)'(BREATH_STEPS);
    localparam logic [SW:0] HALFSTEPS = (SW+1)'(BREATH_STEPS / 2);
    localparam logic [SW:0] LASTSTEP  = (SW+1)'(BREATH_STEPS - 1);

    t_mode                r_mode, n_mode;
    t_mode                r_prior, n_prior;
    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [SW-1:0]        r_step, n_step;
    logic [TIME_W-1:0]    r_wait, n_wait;
    logic                 r_armed, n_armed;
    logic [AGE_W-1:0]     r_age, n_age;
    logic [CODE_BITS-1:0] r_code, n_code;
    logic [BITPOS_W-1:0]  r_bitpos, n_bitpos;

    logic                          run;
    logic                          entered;
    t_mode                         want;
    logic [CODE_BITS+PCODE_W-1:0]  code_ext;
    logic [SW:0]                   step0;
    logic [SW:0]                   step_level;
    logic [BITPOS_W-1:0]           bp0;
    logic [BITPOS_W-1:0]           bp_inc;
    logic [LEVEL_W-1:0]            lvl0;
    logic [CODE_BITS-1:0]          code_at;
    logic [CODE_BITS-1:0]          code_above;

    assign code_ext = {{CODE_BITS{1'b0}}, i_panic_code};

    always_comb begin
        n_mode   = r_mode;
        n_prior  = r_prior;
        n_level  = r_level;
        n_step   = r_step;
        n_wait   = r_wait;
        n_armed  = r_armed;
        n_age    = r_age;
        n_code   = r_code;
        n_bitpos = r_bitpos;
        run      = 1'b0;
        entered  = 1'b0;
        want     = cmd_to_mode(i_cmd);

        if (i_fire) begin
            priority if (i_cmd == CMD_TICK) begin
                if (r_age != AGE_MAX) n_age = r_age + 8'd1;
                if (r_armed) begin
                    if (r_wait <= 12'd1) begin
                        n_wait = '0;
                        run    = 1'b1;
                    end else begin
                        n_wait = r_wait - 12'd1;
                    end
                end
            end else if (i_cmd <= CMD_PANIC) begin
                if (i_cmd == CMD_ACTIVITY) n_age = '0;
                if (i_cmd == CMD_PANIC) n_code = code_ext[CODE_BITS-1:0];
                if (want != r_mode && r_mode != MODE_PANIC) begin
                    n_prior = r_mode;
                    n_mode  = want;
                    run     = 1'b1;
                    entered = 1'b1;
                end
            end else begin
                // unused command codes leave the state alone
            end
        end

        // Activity timeout: rearm the wait, then return to the previous mode (entering
        // it) or toggle the level; a previous mode of activity keeps the mode.
        if (run && !entered && r_mode == MODE_ACTIVITY) begin
            n_wait  = i_cfg.frame_ms;
            n_armed = 1'b1;
            if (n_age > i_cfg.activity_hold_ms) begin
                if (r_prior != MODE_ACTIVITY) begin
                    n_prior = r_mode;
                    n_mode  = r_prior;
                    entered = 1'b1;
                end else begin
                    run = 1'b0;
                end
            end else begin
                n_level = (r_level != '0) ? '0 : i_cfg.bright_level;
                run     = 1'b0;
            end
        end

        step0      = (entered || {1'b0, r_step} >= NSTEPS) ? '0 : {1'b0, r_step};
        step_level = (step0 < HALFSTEPS) ? step0 : LASTSTEP - step0;
        bp0        = entered ? '0 : r_bitpos;
        lvl0       = entered ? '0 : r_level;
        bp_inc     = bp0 + 6'd1;
        code_at    = n_code >> bp0;
        code_above = n_code >> bp_inc;

        if (run) begin
            unique case (n_mode)
                MODE_OFF: begin
                    n_armed = 1'b0;
                    n_wait  = '0;
                    n_level = '0;
                end
                MODE_BREATH: begin
                    n_wait  = i_cfg.frame_ms;
                    n_armed = 1'b1;
                    n_level = LEVEL_W'(step_level);
                    n_step  = (step0 == LASTSTEP) ? '0 : SW'(step0 + 1'b1);
                end
                MODE_ON: begin
                    n_armed = 1'b0;
                    n_wait  = '0;
                    n_level = i_cfg.bright_level;
                end
                MODE_ACTIVITY: begin
                    // only entry reaches here; timeouts were handled above
                    n_wait  = i_cfg.frame_ms;
                    n_armed = 1'b1;
                    n_level = '0;
                end
                MODE_PANIC: begin
                    n_armed = 1'b1;
                    if (lvl0 != '0) begin
                        n_level = '0;
                        if (code_above == '0) begin
                            n_bitpos = '0;
                            n_wait   = i_cfg.pause_ms;
                        end else begin
                            n_bitpos = bp_inc;
                            n_wait   = i_cfg.short_ms;
                        end
                    end else begin
                        n_level  = i_cfg.bright_level;
                        n_bitpos = bp0;
                        n_wait   = code_at[0] ? i_cfg.long_ms : i_cfg.short_ms;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_prior  <= MODE_OFF;
            r_level  <= '0;
            r_step   <= '0;
            r_wait   <= '0;
            r_armed  <= 1'b0;
            r_age    <= '0;
            r_code   <= '0;
            r_bitpos <= '0;
        end else begin
            r_mode   <= n_mode;
            r_prior  <= n_prior;
            r_level  <= n_level;
            r_step   <= n_step;
            r_wait   <= n_wait;
            r_armed  <= n_armed;
            r_age    <= n_age;
            r_code   <= n_code;
            r_bitpos <= n_bitpos;
        end
    end

    assign o_result.pwm_duty = n_level;
    assign o_result.mode     = mode_code(n_mode);

`ifndef SYNTHESIS
    a_panic_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_PANIC |=> r_mode == MODE_PANIC)
        else $error("panic mode was left");
    a_disarmed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> r_wait == '0)
        else $error("wait count left over while disarmed");
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_OFF |-> r_level == '0 && !r_armed)
        else $error("off mode drives the LED or runs a wait");
    a_prior_not_panic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prior != MODE_PANIC)
        else $error("panic recorded as previous mode");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_step} < NSTEPS)
        else $error("breathing step out of range");
`endif

endmodule

// ----- rtl/core/slpc_skid.sv -----
// Two-entry output buffer: result register plus skid register.
// Depends on slpc_pkg for t_result.
module slpc_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  slpc_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output slpc_pkg::t_result o_data,
    input  logic              i_ready
);
    import slpc_pkg::*;

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (i_ready || !r_out_v) begin
            if (r_skid_v) begin
                // drain the skid first; no input is taken while it is full
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_valid;
            end
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_valid && !r_skid_v) begin
            r_skid <= i_data;
        end
    end

endmodule
